FILE: src/range_scan_speckle_filter_assert.svh
// Assertion macros used by the speckle filter top level.
`ifndef RANGE_SCAN_SPECKLE_FILTER_ASSERT_SVH
`define RANGE_SCAN_SPECKLE_FILTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RSSF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RSSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rssf_pkg.sv
// Types, register codes and helpers shared by the speckle filter modules.
`timescale 1ns / 1ps
`default_nettype none
package rssf_pkg;

    localparam int K_W = 4;

    typedef struct packed {
        logic           valid;
        logic [K_W-1:0] k;
    } chord_req_t;

    typedef enum logic [2:0] {
        REG_MIN_RANGE   = 3'd0,
        REG_MAX_RANGE   = 3'd1,
        REG_MAX_GAP     = 3'd2,
        REG_WINDOW_SIZE = 3'd3,
        REG_COS_LOW     = 3'd4,
        REG_COS_HIGH    = 3'd5
    } cfg_reg_t;

    // Picks the Q2.14 cosine for an offset of k steps, k from 1 to 8.
    function automatic logic signed [15:0] cos_pick(input logic [63:0] low,
                                                    input logic [63:0] high,
                                                    input logic [K_W-1:0] k);
        logic [1:0]  slot;
        logic [63:0] word;
        slot = 2'(k - K_W'(1));
        word = (k <= K_W'(4)) ? low : high;
        return $signed(word[16*slot +: 16]);
    endfunction

endpackage
`default_nettype wire

FILE: src/rssf_chord.sv
// Pipelined chord-distance test between a window start and one neighbor.
`timescale 1ns / 1ps
`default_nettype none
module rssf_chord
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire rssf_pkg::chord_req_t req,
    input  wire  [15:0]             a,
    input  wire  [15:0]             b,
    input  wire  [63:0]             cos_low,
    input  wire  [63:0]             cos_high,
    input  wire  [15:0]             gap,
    output logic                    hit,
    output logic                    busy
);
    import rssf_pkg::*;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [31:0]        s1_aa_reg, s1_bb_reg, s1_ab_reg;
    logic signed [15:0] s1_c_reg;
    logic [32:0]        s2_sum_reg;
    logic signed [48:0] s2_abc_reg;
    logic [31:0]        s2_gg_reg;
    logic               s3_ok_reg;
    logic signed [50:0] chord_sq;
    logic signed [50:0] limit;

    // X = 16384*(a*a + b*b) - 2*a*b*c, counted when 0 <= X <= 16384*G*G.
    assign chord_sq = $signed({4'b0, s2_sum_reg, 14'b0}) - $signed({s2_abc_reg, 1'b0}) ;
    assign limit    = $signed({5'b0, s2_gg_reg, 14'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s3_ok_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid && (b != 16'd0);
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s3_ok_reg    <= s2_valid_reg && (chord_sq >= 51'sd0) && (chord_sq <= limit);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_aa_reg  <= a * a;
        s1_bb_reg  <= b * b;
        s1_ab_reg  <= a * b;
        s1_c_reg   <= cos_pick(cos_low, cos_high, req.k);
        s2_sum_reg <= {1'b0, s1_aa_reg} + {1'b0, s1_bb_reg};
        s2_abc_reg <= $signed({1'b0, s1_ab_reg}) * s1_c_reg;
        s2_gg_reg  <= gap * gap;
    end

    assign hit  = s3_valid_reg && s3_ok_reg;
    assign busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;

endmodule
`default_nettype wire

FILE: src/range_scan_speckle_filter.sv
// Speckle filter for a lidar range scan: top level with history memory and sequencer.
//
// Usage: one range sample per request arrives on the s_ stream (s_tdata = range,
// s_tlast = last point of the scan). Filtered samples leave on the m_ stream
// (m_tdata = range, 0 where rejected; m_tlast on the last point of the scan).
// Registers must be written through cfg_we / cfg_index / cfg_data only while the
// block is idle; the block itself does not enforce this. Each sample is written into
// a circular history memory; the sequencer then reads the window start and its
// neighbors one per cycle over the single read port and feeds a pipelined chord
// test. A request runs the neighbor sweep (W is the window) as the accept step, the
// start read (ST_EV_R1, ST_EV_A), the neighbor issue steps and the chord pipeline
// drain. Each result takes a read and a load step, waiting while the receiver is
// not ready. The scan-end request runs a second sweep, then drains up to W+1 results.
// Results trail the input by W+1 samples; a scan of at most W+1 points leaves
// unchanged at its end.
// Reset clears the sequencer, the keep marks, the point counter and loads the
// register defaults; the history memory is not cleared since only entries of the
// current scan are ever read.
// When the receiver stalls, the output register holds its result; the next input
// request can still be taken, and the sequencer waits before loading a new result.
`timescale 1ns / 1ps
`default_nettype none
module range_scan_speckle_filter
#(
    parameter int MAX_WINDOW = 8
)
(
    input  wire         clk,
    input  wire         rst_n,
    // Input stream: tdata = range_in[15:0]; tlast = scan_end.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,
    input  wire         s_tlast,
    // Output stream: tdata = range_out[15:0]; tlast = scan_end_out.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    // Configuration write port.
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [63:0] cfg_data
);
    import rssf_pkg::*;

    `include "range_scan_speckle_filter_assert.svh"

    localparam int DEPTH = 2 * MAX_WINDOW + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int CW    = $clog2(2 * MAX_WINDOW + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_EV_R1, ST_EV_A, ST_EV_ISS, ST_EV_DRAIN, ST_OUT_RD, ST_OUT_LD
    } state_t;

    // Configuration registers.
    logic [15:0] min_range_reg, max_range_reg, gap_reg;
    logic [3:0]  win_size_reg;
    logic [63:0] cos_low_reg, cos_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg <= 16'd0;
            max_range_reg <= 16'hFFFF;
            gap_reg       <= 16'd100;
            win_size_reg  <= 4'd2;
            cos_low_reg   <= 64'd0;
            cos_high_reg  <= 64'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_RANGE:   min_range_reg <= cfg_data[15:0];
                REG_MAX_RANGE:   max_range_reg <= cfg_data[15:0];
                REG_MAX_GAP:     gap_reg       <= cfg_data[15:0];
                REG_WINDOW_SIZE: win_size_reg  <= cfg_data[3:0];
                REG_COS_LOW:     cos_low_reg   <= cfg_data;
                REG_COS_HIGH:    cos_high_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Sequencer state.
    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [15:0]     pts_reg, pts_next;
    logic [15:0]     n_reg, n_next;
    logic [WW-1:0]   swin_reg, swin_next;
    logic [WW-1:0]   w_reg, w_next;
    logic            last_reg, last_next;
    logic            second_reg, second_next;
    logic [AW-1:0]   ds_reg, ds_next;
    logic [AW-1:0]   d_reg, d_next;
    logic [AW-1:0]   od_reg, od_next;
    logic [15:0]     a_reg, a_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [DEPTH-1:0] keep_reg, keep_next;
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     out_data_reg, out_data_next;
    logic            out_last_reg, out_last_next;
    chord_req_t      req_reg, req_next;

    // History memory, one write and one registered read per cycle. Writes only
    // happen on acceptance, read data is used in later states, so they never collide.
    logic [15:0]     hist_mem [DEPTH];
    logic [15:0]     rdata_reg;
    logic            wr_en;
    logic [AW-1:0]   rd_depth;
    logic [AW-1:0]   rd_addr;
    logic [AW:0]     addr_sum;

    logic            chord_hit, chord_busy;

    logic [WW-1:0]   w_sel;
    logic            oor;
    logic            fil;
    logic            post, finish;
    logic [AW-1:0]   diff;
    logic [AW-1:0]   top_depth;
    logic [DEPTH-1:0] mask;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Physical address of a history depth: newest sample sits at the head.
    assign addr_sum = {1'b0, head_reg} + (AW+1)'(DEPTH) - {1'b0, rd_depth};
    assign rd_addr  = (addr_sum >= (AW+1)'(DEPTH)) ? AW'(addr_sum - (AW+1)'(DEPTH))
                                                   : AW'(addr_sum);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[head_next] <= s_tdata;
        end
        rdata_reg <= hist_mem[rd_addr];
    end

    // The window is latched at the first point of a scan and clamped to 1..MAX_WINDOW.
    always_comb
    begin
        if (pts_reg != 16'd0)
            w_sel = swin_reg;
        else if (win_size_reg == 4'd0)
            w_sel = WW'(1);
        else if (win_size_reg > 4'(MAX_WINDOW))
            w_sel = WW'(MAX_WINDOW);
        else
            w_sel = WW'(win_size_reg);
    end

    assign oor       = (s_tdata > max_range_reg) || (s_tdata < min_range_reg);
    assign fil       = n_reg > 16'(w_reg);
    assign diff      = (ds_reg > d_reg) ? (ds_reg - d_reg) : (d_reg - ds_reg);
    assign top_depth = (n_reg < 16'(w_reg)) ? AW'(n_reg) : AW'(w_reg);

    // Marks the start and the W-1 points after it (depths ds down to ds-W+1).
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            mask[i] = ((AW+1)'(i) <= {1'b0, ds_reg})
                   && ((AW+1)'(i) + (AW+1)'(w_reg) > {1'b0, ds_reg});
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        pts_next       = pts_reg;
        n_next         = n_reg;
        swin_next      = swin_reg;
        w_next         = w_reg;
        last_next      = last_reg;
        second_next    = second_reg;
        ds_next        = ds_reg;
        d_next         = d_reg;
        od_next        = od_reg;
        a_next         = a_reg;
        cnt_next       = cnt_reg + CW'(chord_hit);
        keep_next      = keep_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        req_next       = '0;
        wr_en          = 1'b0;
        rd_depth       = od_reg;
        post           = 1'b0;
        finish         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next      = pts_reg;
                    w_next      = w_sel;
                    swin_next   = w_sel;
                    last_next   = s_tlast;
                    head_next   = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                    wr_en       = 1'b1;
                    keep_next   = {keep_reg[DEPTH-2:0], oor};
                    ds_next     = AW'(w_sel);
                    second_next = 1'b0;
                    state_next  = ST_EV_R1;
                end
            end
            ST_EV_R1:
            begin
                rd_depth = ds_reg;
                if (16'(ds_reg) > n_reg)
                    post = 1'b1;
                else
                    state_next = ST_EV_A;
            end
            ST_EV_A:
            begin
                a_next     = rdata_reg;
                d_next     = '0;
                cnt_next   = '0;
                state_next = ST_EV_ISS;
            end
            ST_EV_ISS:
            begin
                rd_depth       = d_reg;
                req_next.valid = (d_reg != ds_reg) && (16'(d_reg) <= n_reg)
                              && ((AW+1)'(d_reg) + (AW+1)'(w_reg) >= (AW+1)'(ds_reg));
                req_next.k     = K_W'(diff);
                if ((AW+1)'(d_reg) == (AW+1)'(ds_reg) + (AW+1)'(w_reg))
                    state_next = ST_EV_DRAIN;
                else
                    d_next = d_reg + AW'(1);
            end
            ST_EV_DRAIN:
            begin
                if (!req_reg.valid && !chord_busy)
                begin
                    if (cnt_reg >= CW'(w_reg))
                        keep_next = keep_reg | mask;
                    post = 1'b1;
                end
            end
            ST_OUT_RD:
            begin
                rd_depth = od_reg;
                if (!out_valid_reg || m_tready)
                    state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                out_valid_next = 1'b1;
                out_data_next  = (fil && !keep_reg[od_reg]) ? 16'd0 : rdata_reg;
                out_last_next  = last_reg && (od_reg == '0);
                if (last_reg && (od_reg != '0))
                begin
                    od_next    = od_reg - AW'(1);
                    state_next = ST_OUT_RD;
                end
                else
                    finish = 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase

        // After a window evaluation: emit one result, finish without one, run the scan-end sweep, or flush.
        if (post)
        begin
            if (second_reg)
            begin
                od_next    = AW'(w_reg);
                state_next = ST_OUT_RD;
            end
            else if (!last_reg)
            begin
                if (fil)
                begin
                    od_next    = AW'(w_reg) + AW'(1);
                    state_next = ST_OUT_RD;
                end
                else
                    finish = 1'b1;
            end
            else if (fil)
            begin
                ds_next     = AW'(w_reg) - AW'(1);
                second_next = 1'b1;
                state_next  = ST_EV_R1;
            end
            else
            begin
                od_next    = top_depth;
                state_next = ST_OUT_RD;
            end
        end

        if (finish)
        begin
            if (last_reg)
            begin
                pts_next  = 16'd0;
                keep_next = '0;
            end
            else if (pts_reg != 16'hFFFF)
                pts_next = pts_reg + 16'd1;
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            pts_reg       <= 16'd0;
            n_reg         <= 16'd0;
            swin_reg      <= WW'(2);
            w_reg         <= WW'(2);
            last_reg      <= 1'b0;
            second_reg    <= 1'b0;
            ds_reg        <= '0;
            d_reg         <= '0;
            od_reg        <= '0;
            a_reg         <= 16'd0;
            cnt_reg       <= '0;
            keep_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= 16'd0;
            out_last_reg  <= 1'b0;
            req_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            pts_reg       <= pts_next;
            n_reg         <= n_next;
            swin_reg      <= swin_next;
            w_reg         <= w_next;
            last_reg      <= last_next;
            second_reg    <= second_next;
            ds_reg        <= ds_next;
            d_reg         <= d_next;
            od_reg        <= od_next;
            a_reg         <= a_next;
            cnt_reg       <= cnt_next;
            keep_reg      <= keep_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
            req_reg       <= req_next;
        end
    end

    rssf_chord u_chord
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_reg),
        .a        (a_reg),
        .b        (rdata_reg),
        .cos_low  (cos_low_reg),
        .cos_high (cos_high_reg),
        .gap      (gap_reg),
        .hit      (chord_hit),
        .busy     (chord_busy)
    );

    // The chord pipeline has drained whenever a new sample can be taken.
    `RSSF_ASSERT_SAME(a_idle_drained, state_reg == ST_IDLE,
        !chord_busy && !req_reg.valid, "chord pipeline busy while idle")
    // A new result appears only from the result-load step.
    `RSSF_ASSERT_SAME(a_out_from_load, $rose(out_valid_reg),
        $past(state_reg == ST_OUT_LD), "result loaded outside load step")
    // A stalled output keeps the sequencer from fetching the next result.
    `RSSF_ASSERT_NEXT(a_stall_waits, state_reg == ST_OUT_RD && out_valid_reg && !m_tready,
        state_reg == ST_OUT_RD, "result fetched over a stalled output")

endmodule
`default_nettype wire
